>>> hdl/bamq_pkg.sv
// Package for the blockwise absmax quantiser: sizes, codes, the sequencer
// state type and the divider request type. No dependencies.
package bamq_pkg;

    localparam int BLOCK_MAX = 32;
    localparam int ADDR_W    = $clog2(BLOCK_MAX);
    localparam int CNT_W     = $clog2(BLOCK_MAX + 1);
    localparam int DVD_W     = 41;   // widest dividend: maxabs * 512 + qmax
    localparam int DVS_W     = 34;   // widest divisor: 2 * maxabs, plus a guard bit
    localparam int STEP_W    = 6;
    localparam int QMAX_W    = 7;
    localparam int SCALE_W   = 40;

    localparam logic [SCALE_W-1:0] ONE_Q24 = SCALE_W'(64'd16777216);
    localparam logic [STEP_W-1:0]  SCALE_STEPS = STEP_W'(DVD_W);
    localparam logic [STEP_W-1:0]  Q_STEPS     = STEP_W'(8);

    // Width mode codes.
    localparam logic [1:0] MODE_2B = 2'd0;
    localparam logic [1:0] MODE_4B = 2'd1;
    localparam logic [1:0] MODE_8B = 2'd2;

    // Register indexes of the configuration port.
    localparam logic REG_WIDTH_MODE = 1'b0;
    localparam logic REG_BLOCK_LEN  = 1'b1;

    typedef enum logic [2:0] {
        S_FILL,
        S_SCALE,
        S_SWAIT,
        S_RD,
        S_NUM,
        S_QDIV,
        S_QWAIT,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } t_div_req;

    function automatic logic [QMAX_W-1:0] qmax_of(input logic [1:0] mode);
        logic [QMAX_W-1:0] q;
        case (mode)
            MODE_2B: q = QMAX_W'(1);
            MODE_4B: q = QMAX_W'(7);
            default: q = QMAX_W'(127);
        endcase
        return q;
    endfunction

endpackage

>>> hdl/bamq_store.sv
// Sample buffer of the absmax quantiser: one write port, one read port with
// registered read data. Depends on bamq_pkg.
module bamq_store
    import bamq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [31:0]       i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [31:0]       o_rd_data
);

    logic [31:0] r_mem [BLOCK_MAX];
    logic [31:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hdl/bamq_div.sv
// Restoring divider, one quotient bit per cycle, for the scale and for each
// quantised value. Depends on bamq_pkg.
module bamq_div
    import bamq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic [DVD_W-1:0] o_quotient,
    output logic             o_done
);

    logic [DVS_W-1:0]  r_rem;
    logic [DVD_W-1:0]  r_dvd;
    logic [DVD_W-1:0]  r_quo;
    logic [DVS_W-1:0]  r_dvs;
    logic [STEP_W-1:0] r_cnt;
    logic              r_done;

    logic [DVS_W:0]    n_trial;
    logic              n_ge;

    // Trial subtraction of one step.
    always_comb begin
        n_trial = {r_rem, r_dvd[DVD_W-1]};
        n_ge    = (n_trial >= {1'b0, r_dvs});
    end

    // Control: the step counter and the completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_req.start) begin
            r_cnt  <= i_req.steps;
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - STEP_W'(1);
            r_done <= (r_cnt == STEP_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    // Datapath. The bits above the processed ones form the starting
    // remainder; the caller guarantees it is below the divisor.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= DVS_W'(i_dividend >> i_req.steps);
            r_dvd <= i_dividend << (STEP_W'(DVD_W) - i_req.steps);
            r_dvs <= i_divisor;
            r_quo <= '0;
        end else if (r_cnt != '0) begin
            r_rem <= n_ge ? DVS_W'(n_trial - {1'b0, r_dvs}) : DVS_W'(n_trial);
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            r_quo <= {r_quo[DVD_W-2:0], n_ge};
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

>>> hdl/block_absmax_quantizer_core.sv
// After a closing sample the sequencer runs the 41-step scale division, then for each sample
// reads it, forms the numerator and runs an 8-step division; an all-zero block skips both.
// Input: one sample per cycle while a block fills; the block then drains one result at a time,
// each held back by any stall on the result side, and no input is accepted meanwhile.
// Reset (i_rst_n, synchronous, active low) empties the block and sets 8-bit mode and block
// length 32. Uses bamq_pkg.
module block_absmax_quantizer_core
    import bamq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] sample
    input  logic        s_axis_tlast,   // tensor_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [7:0] qvalue, [47:8] block_scale
    output logic        m_axis_tlast,   // block_end
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    t_state r_state, n_state;

    logic [1:0]         r_width_mode;
    logic [5:0]         r_block_len;
    logic [CNT_W-1:0]   r_fill;
    logic [31:0]        r_maxabs;
    logic [CNT_W-1:0]   r_count;
    logic [ADDR_W-1:0]  r_idx;
    logic [SCALE_W-1:0] r_scale;
    logic [DVD_W-1:0]   r_num;
    logic               r_neg;
    logic [7:0]         r_q;
    logic               r_out_valid;
    logic [7:0]         r_out_q;
    logic [SCALE_W-1:0] r_out_scale;
    logic               r_out_last;

    logic               in_acc;
    logic [31:0]        in_mag;
    logic [CNT_W-1:0]   n_fill;
    logic [CNT_W-1:0]   eff_len;
    logic               close_blk;
    logic [QMAX_W-1:0]  qmax;
    logic [31:0]        rd_data;
    logic [31:0]        rd_mag;
    logic               slot_free;
    logic               last_item;
    logic [7:0]         q_clamped;

    t_div_req           div_req;
    logic [DVD_W-1:0]   div_dividend;
    logic [DVS_W-1:0]   div_divisor;
    logic [DVD_W-1:0]   div_quo;
    logic               div_done;

    // Input side and block closing.
    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign in_mag    = s_axis_tdata[31] ? (32'd0 - s_axis_tdata) : s_axis_tdata;
    assign n_fill    = r_fill + CNT_W'(1);
    assign qmax      = qmax_of(r_width_mode);
    assign slot_free = !r_out_valid || m_axis_tready;
    assign last_item = ({1'b0, r_idx} == CNT_W'(r_count - CNT_W'(1)));
    assign rd_mag    = rd_data[31] ? (32'd0 - rd_data) : rd_data;

    always_comb begin
        if (r_block_len == 6'd0) begin
            eff_len = CNT_W'(1);
        end else if (32'(r_block_len) > 32'(BLOCK_MAX)) begin
            eff_len = CNT_W'(BLOCK_MAX);
        end else begin
            eff_len = CNT_W'(r_block_len);
        end
        close_blk = s_axis_tlast || (n_fill >= eff_len);
        q_clamped = (r_q > 8'(qmax)) ? 8'(qmax) : r_q;
    end

    // Next state and divider requests.
    always_comb begin
        n_state       = r_state;
        div_req.start = 1'b0;
        div_req.steps = Q_STEPS;
        div_dividend  = r_num;
        div_divisor   = {1'b0, r_maxabs, 1'b0};
        s_axis_tready = (r_state == S_FILL);
        case (r_state)
            S_FILL: begin
                if (in_acc && close_blk) begin
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                if (r_maxabs == 32'd0) begin
                    n_state = S_RD;
                end else begin
                    div_req.start = 1'b1;
                    div_req.steps = SCALE_STEPS;
                    div_dividend  = {r_maxabs, 9'd0} + DVD_W'(qmax);
                    div_divisor   = DVS_W'({qmax, 1'b0});
                    n_state       = S_SWAIT;
                end
            end
            S_SWAIT: begin
                if (div_done) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_NUM;
            end
            S_NUM: begin
                n_state = S_QDIV;
            end
            S_QDIV: begin
                if (r_maxabs == 32'd0) begin
                    n_state = S_EMIT;
                end else begin
                    div_req.start = 1'b1;
                    n_state       = S_QWAIT;
                end
            end
            S_QWAIT: begin
                if (div_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    n_state = last_item ? S_FILL : S_RD;
                end
            end
            default: begin
                n_state = S_FILL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FILL;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers, written only while idle.
    assign o_cfg_ready = (r_state == S_FILL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_mode <= MODE_8B;
            r_block_len  <= 6'd32;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_WIDTH_MODE: r_width_mode <= i_cfg_data[1:0];
                REG_BLOCK_LEN:  r_block_len  <= i_cfg_data[5:0];
                default:        r_block_len  <= r_block_len;
            endcase
        end
    end

    // Block control: fill count, running maximum and drain index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_maxabs <= '0;
            r_count  <= '0;
            r_idx    <= '0;
        end else if (r_state == S_FILL) begin
            if (in_acc) begin
                r_fill <= n_fill;
                if (in_mag > r_maxabs) begin
                    r_maxabs <= in_mag;
                end
                r_count <= n_fill;
                r_idx   <= '0;
            end
        end else if (r_state == S_EMIT && slot_free) begin
            if (last_item) begin
                r_fill   <= '0;
                r_maxabs <= '0;
            end else begin
                r_idx <= r_idx + ADDR_W'(1);
            end
        end
    end

    // Scale, numerator and quotient registers.
    always_ff @(posedge i_clk) begin
        if (r_state == S_SCALE) begin
            r_scale <= ONE_Q24;
        end else if (r_state == S_SWAIT && div_done) begin
            r_scale <= div_quo[SCALE_W-1:0];
        end
        if (r_state == S_NUM) begin
            r_num <= {1'b0, 39'(rd_mag) * 39'(qmax), 1'b0} + DVD_W'(r_maxabs);
            r_neg <= rd_data[31];
            r_q   <= 8'd0;
        end else if (r_state == S_QWAIT && div_done) begin
            r_q <= div_quo[7:0];
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_EMIT && slot_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && slot_free) begin
            r_out_q     <= r_neg ? (8'd0 - q_clamped) : q_clamped;
            r_out_scale <= r_scale;
            r_out_last  <= last_item;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_scale, r_out_q};
    assign m_axis_tlast  = r_out_last;

    bamq_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (in_acc),
        .i_wr_addr (r_fill[ADDR_W-1:0]),
        .i_wr_data (s_axis_tdata),
        .i_rd_addr (r_idx),
        .o_rd_data (rd_data)
    );

    bamq_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_quotient (div_quo),
        .o_done     (div_done)
    );

    // The buffer never holds more than one block.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) <= 32'(BLOCK_MAX))
        else $error("fill count beyond buffer depth");

    // While draining, the read index stays inside the closed block.
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_FILL) |-> ({1'b0, r_idx} < r_count))
        else $error("drain index outside block");

    // A division completes only while the sequencer waits for it.
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_SWAIT || r_state == S_QWAIT))
        else $error("unexpected divider completion");

    // The last result of a block returns the sequencer to filling.
    a_end_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && slot_free && last_item) |=> (r_state == S_FILL && r_fill == '0))
        else $error("block not emptied after last result");

endmodule
